/* design/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: stable priority queue shared definitions
// Operation codes, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int PRIO_W = 4;
  localparam int OCC_W  = 5;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [PRIO_W-1:0] new_prio;
  } spq_ctrl_t;

endpackage

/* design/stable_priority_queue.sv */
// The result word appears with done_o in the cycle after start_i.
// Throughput: one word per cycle; busy_o stays low, every slot updates at once.
// The receiver cannot stall; each result is on the ports for one cycle.
// Reset clears the entry count and the result strobe; slot contents are
// not reset and are only read below the entry count.
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded stable priority queue
// A chain of slot cells kept sorted by priority, highest first, with equal
// priorities in arrival order. Enqueue inserts, dequeue pops the front.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       func_i,
  input  logic [ID_WIDTH-1:0]        process_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] priority_req_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [ID_WIDTH-1:0]        served_id_o,
  output logic [spq_pkg::PRIO_W-1:0] served_priority_o,
  output logic [spq_pkg::OCC_W-1:0]  occupancy_o
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  spq_status_e      status_q, status_d;
  logic [ID_WIDTH-1:0] sid_q, sid_d;
  logic [PRIO_W-1:0]   spr_q, spr_d;
  logic [OCC_W-1:0]    occ_q;

  logic full, empty;
  spq_ctrl_t ctrl;

  logic [QUEUE_DEPTH-1:0] ge;
  logic [ID_WIDTH-1:0]    cell_id   [QUEUE_DEPTH];
  logic [PRIO_W-1:0]      cell_prio [QUEUE_DEPTH];

  assign busy_o = 1'b0;
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  always_comb begin
    ctrl.enq      = 1'b0;
    ctrl.deq      = 1'b0;
    ctrl.new_prio = priority_req_i;
    count_d       = count_q;
    status_d      = ST_OK;
    sid_d         = '0;
    spr_d         = '0;
    if (start_i) begin
      case (func_i)
        FUNC_ENQ: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.enq = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end
        FUNC_DEQ: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.deq = 1'b1;
            count_d  = count_q - CNT_W'(1);
            sid_d    = cell_id[0];
            spr_d    = cell_prio[0];
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                left_ge;
    logic [ID_WIDTH-1:0] left_id;
    logic [PRIO_W-1:0]   left_prio;
    logic [ID_WIDTH-1:0] right_id;
    logic [PRIO_W-1:0]   right_prio;

    if (i == 0) begin : g_head
      assign left_ge   = 1'b1;
      assign left_id   = process_id_i;
      assign left_prio = priority_req_i;
    end else begin : g_body
      assign left_ge   = ge[i-1];
      assign left_id   = cell_id[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_id   = cell_id[i];
      assign right_prio = cell_prio[i];
    end else begin : g_mid
      assign right_id   = cell_id[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_id_i     (process_id_i),
      .valid_i      (count_q > CNT_W'(i)),
      .left_ge_i    (left_ge),
      .left_id_i    (left_id),
      .left_prio_i  (left_prio),
      .right_id_i   (right_id),
      .right_prio_i (right_prio),
      .ge_o         (ge[i]),
      .id_o         (cell_id[i]),
      .prio_o       (cell_prio[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    sid_q    <= sid_d;
    spr_q    <= spr_d;
    occ_q    <= OCC_W'(count_d);
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign served_id_o       = sid_q;
  assign served_priority_o = spr_q;
  assign occupancy_o       = occ_q;

endmodule

/* design/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one id and priority. On enqueue it keeps its word, takes the new word
// or takes its left neighbor's word; on dequeue it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int ID_WIDTH = 16
) (
  input  logic                       clk_i,
  input  spq_pkg::spq_ctrl_t         ctrl_i,
  input  logic [ID_WIDTH-1:0]        new_id_i,
  input  logic                       valid_i,
  input  logic                       left_ge_i,
  input  logic [ID_WIDTH-1:0]        left_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio_i,
  input  logic [ID_WIDTH-1:0]        right_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio_i,
  output logic                       ge_o,
  output logic [ID_WIDTH-1:0]        id_o,
  output logic [spq_pkg::PRIO_W-1:0] prio_o
);
  import spq_pkg::*;

  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;

  assign ge_o   = valid_i && (prio_q >= ctrl_i.new_prio);
  assign id_o   = id_q;
  assign prio_o = prio_q;

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    if (ctrl_i.enq && !ge_o) begin
      if (left_ge_i) begin
        id_d   = new_id_i;
        prio_d = ctrl_i.new_prio;
      end else begin
        id_d   = left_id_i;
        prio_d = left_prio_i;
      end
    end else if (ctrl_i.deq) begin
      id_d   = right_id_i;
      prio_d = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

endmodule

/* verif/spq_service_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_service_checker: service order checker for the stable priority queue
// Keeps its own sorted copy of the queue, predicts the word that answers
// each accepted command and compares every strobed result against it.
// ----------------------------------------------------------------------------
module spq_service_checker #(
  parameter int DEPTH = 16,
  parameter int ID_W  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       func_i,
  input  logic [ID_W-1:0]            process_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] priority_req_i,
  input  logic                       done_i,
  input  logic [1:0]                 status_i,
  input  logic [ID_W-1:0]            served_id_i,
  input  logic [spq_pkg::PRIO_W-1:0] served_priority_i,
  input  logic [spq_pkg::OCC_W-1:0]  occupancy_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);
  import spq_pkg::*;

  typedef struct packed {
    spq_status_e       status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [OCC_W-1:0]  occ;
  } served_word_t;

  logic [ID_W-1:0]   slot_id   [DEPTH];
  logic [PRIO_W-1:0] slot_prio [DEPTH];
  int                held;
  int                fails;
  served_word_t      pending_answers[$];
  served_word_t      want;
  served_word_t      got;
  served_word_t      next_word;

  task automatic apply_queue_op(input logic op, input logic [ID_W-1:0] id,
                                input logic [PRIO_W-1:0] prio, output served_word_t w);
    int pos;
    w = '0;
    w.status = ST_OK;
    if (op == FUNC_ENQ) begin
      if (held >= DEPTH) begin
        w.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held && slot_prio[pos] >= prio) pos++;
        for (int i = held; i > pos; i--) begin
          slot_id[i]   = slot_id[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_id[pos]   = id;
        slot_prio[pos] = prio;
        held++;
      end
    end else if (held == 0) begin
      w.status = ST_EMPTY;
    end else begin
      w.id   = slot_id[0];
      w.prio = slot_prio[0];
      for (int i = 1; i < held; i++) begin
        slot_id[i-1]   = slot_id[i];
        slot_prio[i-1] = slot_prio[i];
      end
      held--;
    end
    w.occ = OCC_W'(held);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      fails = 0;
      pending_answers.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (done_i) begin
        got = {spq_status_e'(status_i), served_id_i, served_priority_i, occupancy_i};
        if (pending_answers.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected word: status %0d id %h prio %0d occ %0d",
                     $realtime, got.status, got.id, got.prio, got.occ);
          fails++;
        end else begin
          want = pending_answers.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("%0t: mismatch (st id pr occ): exp %0d %h %0d %0d got %0d %h %0d %0d",
                       $realtime,
                       want.status, want.id, want.prio, want.occ,
                       got.status, got.id, got.prio, got.occ);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_queue_op(func_i, process_id_i, priority_req_i, next_word);
        pending_answers.push_back(next_word);
      end
      mismatch_count_o <= fails;
      pending_o        <= pending_answers.size();
    end
  end

endmodule

/* verif/stable_priority_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: regression for the stable priority queue
// Directed fill, overflow and underflow commands, then bursts of random
// enqueue and dequeue words with shifting mix; a checker judges the results.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int ID_W        = 16;
  localparam int RAND_WORDS  = 550;
  localparam int STALL_LIMIT = 2000;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start_i        = 1'b0;
  logic              func_i         = FUNC_ENQ;
  logic [ID_W-1:0]   process_id_i   = '0;
  logic [PRIO_W-1:0] priority_req_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [ID_W-1:0]   served_id_o;
  logic [PRIO_W-1:0] served_priority_o;
  logic [OCC_W-1:0]  occupancy_o;
  int                mismatch_count;
  int                pending;
  int                quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  stable_priority_queue #(
    .QUEUE_DEPTH (DEPTH),
    .ID_WIDTH    (ID_W)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .process_id_i      (process_id_i),
    .priority_req_i    (priority_req_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .served_id_o       (served_id_o),
    .served_priority_o (served_priority_o),
    .occupancy_o       (occupancy_o)
  );

  spq_service_checker #(
    .DEPTH (DEPTH),
    .ID_W  (ID_W)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .func_i            (func_i),
    .process_id_i      (process_id_i),
    .priority_req_i    (priority_req_i),
    .done_i            (done_o),
    .status_i          (status_o),
    .served_id_i       (served_id_o),
    .served_priority_i (served_priority_o),
    .occupancy_i       (occupancy_o),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("stable_priority_queue regression: fail");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] prio);
    @(negedge clk_i);
    start_i        <= 1'b1;
    func_i         <= op;
    process_id_i   <= id;
    priority_req_i <= prio;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i        <= 1'b0;
      func_i         <= 1'($urandom);
      process_id_i   <= ID_W'($urandom);
      priority_req_i <= PRIO_W'($urandom);
    end
  endtask

  task automatic settle_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int            sent;
    int            enq_pct;
    int            burst;
    bit            narrow;
    bit            mid_drained;
    logic [PRIO_W-1:0] prio;
    logic          op;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // underflow, fill with repeated priorities, overflow, partial drain
    send_word(FUNC_DEQ, '1, '1);
    for (int i = 0; i < DEPTH; i++) begin
      prio = (i % 3 == 0) ? 4'd15 : (i % 3 == 1) ? 4'd0 : 4'd7;
      send_word(FUNC_ENQ, (i == 0) ? '0 : (i == 1) ? '1 : ID_W'(i * 16'h0f0f + 1), prio);
    end
    send_word(FUNC_ENQ, 16'habcd, 4'd15);
    repeat (4) send_word(FUNC_DEQ, ID_W'($urandom), PRIO_W'($urandom));
    settle_results();

    sent        = 0;
    enq_pct     = 50;
    narrow      = 1'b0;
    mid_drained = 1'b0;
    while (sent < RAND_WORDS) begin
      if (sent % 64 < 8) begin
        case ($urandom_range(0, 3))
          0: enq_pct = 25;
          1: enq_pct = 50;
          2: enq_pct = 75;
          default: enq_pct = 90;
        endcase
        narrow = 1'($urandom);
      end
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        op   = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        prio = narrow ? PRIO_W'($urandom_range(0, 2) * 7) : PRIO_W'($urandom);
        send_word(op, ID_W'($urandom), prio);
        sent++;
      end
      if (!mid_drained && sent >= RAND_WORDS / 2) begin
        settle_results();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end

    settle_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("stable_priority_queue regression: pass");
    end else begin
      $display("stable_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
